/* src/sap_pkg.sv */
package sap_pkg;

    localparam int SAMPLE_W = 24;
    localparam int COEF_W   = 24;
    localparam int PROD_W   = SAMPLE_W + COEF_W;
    localparam int SHIFT    = COEF_W - 2;
    localparam int RPROD_W  = PROD_W - SHIFT;
    localparam int SUM_W    = RPROD_W + 1;

    localparam logic [1:0] ORDER_FIRST  = 2'd1;
    localparam logic [1:0] ORDER_SECOND = 2'd2;

    localparam logic [2:0] FORM_DF1  = 3'd1;
    localparam logic [2:0] FORM_DF1T = 3'd2;
    localparam logic [2:0] FORM_DF2  = 3'd3;
    localparam logic [2:0] FORM_DF2T = 3'd4;
    localparam logic [2:0] FORM_LAT  = 3'd5;
    localparam logic [2:0] FORM_LATD = 3'd6;

    localparam logic [1:0] CFG_ORDER = 2'd0;
    localparam logic [1:0] CFG_FORM  = 2'd1;
    localparam logic [1:0] CFG_COEF0 = 2'd2;
    localparam logic [1:0] CFG_COEF1 = 2'd3;

    // unity in Q2.22
    localparam logic signed [COEF_W-1:0] COEF_ONE = COEF_W'(1) <<< SHIFT;

    typedef enum logic [3:0] {
        R_ZERO, R_LIN, R_RIN, R_T0, R_T1, R_LY, R_RY,
        R_LD0, R_LD1, R_LO0, R_LO1, R_RD0, R_RD1
    } reg_sel_t;

    typedef enum logic [1:0] {CS_C0, CS_C1, CS_ONE} coef_sel_t;

    typedef enum logic [2:0] {
        M_PASS, M_FO, M_DF1, M_DF1T, M_DF2, M_DF2T, M_LAT, M_LATD
    } mode_t;

    typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DONE} state_t;

    // dst = sat(a +/- round(coef * x))
    typedef struct packed {
        reg_sel_t  dst;
        reg_sel_t  a;
        coef_sel_t coef;
        logic      sub;
        reg_sel_t  x;
    } uop_t;

    typedef struct packed {
        logic load_in;
        logic exec;
        uop_t op;
        logic load_out;
    } dp_cmd_t;

    function automatic uop_t mk(reg_sel_t dst, reg_sel_t a, coef_sel_t coef,
                                logic sub, reg_sel_t x);
        uop_t u;
        u.dst  = dst;
        u.a    = a;
        u.coef = coef;
        u.sub  = sub;
        u.x    = x;
        return u;
    endfunction

    function automatic uop_t nop_op();
        return mk(R_ZERO, R_ZERO, CS_ONE, 1'b0, R_ZERO);
    endfunction

    function automatic mode_t decode_mode(logic [1:0] order, logic [2:0] form);
        mode_t m;
        m = M_PASS;
        if (order == ORDER_FIRST)
        begin
            m = M_FO;
        end
        else if (order == ORDER_SECOND)
        begin
            unique case (form)
                FORM_DF1:  m = M_DF1;
                FORM_DF1T: m = M_DF1T;
                FORM_DF2:  m = M_DF2;
                FORM_DF2T: m = M_DF2T;
                FORM_LAT:  m = M_LAT;
                FORM_LATD: m = M_LATD;
                default:   m = M_PASS;
            endcase
        end
        return m;
    endfunction

    function automatic logic [3:0] mode_len(mode_t m);
        logic [3:0] n;
        unique case (m)
            M_PASS:  n = 4'd2;
            M_FO:    n = 4'd4;
            M_DF1:   n = 4'd15;
            M_DF1T:  n = 4'd14;
            M_DF2:   n = 4'd14;
            M_DF2T:  n = 4'd11;
            M_LAT:   n = 4'd10;
            M_LATD:  n = 4'd6;
            default: n = 4'd2;
        endcase
        return n;
    endfunction

    function automatic uop_t df2_op(reg_sel_t x, reg_sel_t d0, reg_sel_t d1,
                                    reg_sel_t y, logic [3:0] k);
        uop_t u;
        unique case (k)
            4'd0:    u = mk(R_T0, x,      CS_C0,  1'b1, d0);
            4'd1:    u = mk(R_T0, R_T0,   CS_C1,  1'b1, d1);
            4'd2:    u = mk(y,    R_ZERO, CS_C1,  1'b0, R_T0);
            4'd3:    u = mk(y,    y,      CS_C0,  1'b0, d0);
            4'd4:    u = mk(y,    y,      CS_ONE, 1'b0, d1);
            4'd5:    u = mk(d1,   d0,     CS_ONE, 1'b0, R_ZERO);
            4'd6:    u = mk(d0,   R_T0,   CS_ONE, 1'b0, R_ZERO);
            default: u = nop_op();
        endcase
        return u;
    endfunction

    function automatic uop_t lat_op(reg_sel_t x, reg_sel_t d0, reg_sel_t d1,
                                    reg_sel_t y, logic [3:0] k);
        uop_t u;
        unique case (k)
            4'd0:    u = mk(R_T0, x,    CS_C1,  1'b1, d1);
            4'd1:    u = mk(y,    d1,   CS_C1,  1'b0, R_T0);
            4'd2:    u = mk(R_T1, R_T0, CS_C0,  1'b1, d0);
            4'd3:    u = mk(d1,   d0,   CS_C0,  1'b0, R_T1);
            4'd4:    u = mk(d0,   R_T1, CS_ONE, 1'b0, R_ZERO);
            default: u = nop_op();
        endcase
        return u;
    endfunction

    function automatic uop_t get_uop(mode_t m, logic [3:0] k);
        uop_t u;
        u = nop_op();
        unique case (m)
            M_PASS:
            begin
                u = (k == 4'd0) ? mk(R_LY, R_LIN, CS_ONE, 1'b0, R_ZERO)
                                : mk(R_RY, R_RIN, CS_ONE, 1'b0, R_ZERO);
            end
            M_FO:
            begin
                unique case (k)
                    4'd0:    u = mk(R_T0,  R_LIN, CS_C0,  1'b1, R_LD0);
                    4'd1:    u = mk(R_LY,  R_LD0, CS_C0,  1'b0, R_T0);
                    4'd2:    u = mk(R_LD0, R_T0,  CS_ONE, 1'b0, R_ZERO);
                    default: u = mk(R_RY,  R_RIN, CS_ONE, 1'b0, R_ZERO);
                endcase
            end
            M_DF1:
            begin
                unique case (k)
                    4'd0:    u = mk(R_LY,  R_LD1, CS_C0,  1'b0, R_LD0);
                    4'd1:    u = mk(R_LY,  R_LY,  CS_C1,  1'b0, R_LIN);
                    4'd2:    u = mk(R_LY,  R_LY,  CS_C1,  1'b1, R_LO1);
                    4'd3:    u = mk(R_LY,  R_LY,  CS_C0,  1'b1, R_LO0);
                    4'd4:    u = mk(R_LD1, R_LD0, CS_ONE, 1'b0, R_ZERO);
                    4'd5:    u = mk(R_LD0, R_LIN, CS_ONE, 1'b0, R_ZERO);
                    4'd6:    u = mk(R_LO1, R_LO0, CS_ONE, 1'b0, R_ZERO);
                    4'd7:    u = mk(R_LO0, R_LY,  CS_ONE, 1'b0, R_ZERO);
                    default: u = df2_op(R_RIN, R_RD0, R_RD1, R_RY, k - 4'd8);
                endcase
            end
            M_DF1T:
            begin
                unique case (k)
                    4'd0:    u = mk(R_T0,  R_LIN,  CS_ONE, 1'b0, R_LD0);
                    4'd1:    u = mk(R_LD0, R_LD1,  CS_C0,  1'b1, R_T0);
                    4'd2:    u = mk(R_T1,  R_ZERO, CS_C1,  1'b0, R_T0);
                    4'd3:    u = mk(R_LD1, R_ZERO, CS_ONE, 1'b1, R_T1);
                    4'd4:    u = mk(R_LY,  R_LO0,  CS_C1,  1'b0, R_T0);
                    4'd5:    u = mk(R_LO0, R_LO1,  CS_C0,  1'b0, R_T0);
                    4'd6:    u = mk(R_LO1, R_T0,   CS_ONE, 1'b0, R_ZERO);
                    default: u = df2_op(R_RIN, R_RD0, R_RD1, R_RY, k - 4'd7);
                endcase
            end
            M_DF2:
            begin
                u = (k < 4'd7) ? df2_op(R_LIN, R_LD0, R_LD1, R_LY, k)
                               : df2_op(R_RIN, R_RD0, R_RD1, R_RY, k - 4'd7);
            end
            M_DF2T:
            begin
                unique case (k)
                    4'd0:    u = mk(R_LY,  R_LD0, CS_C1, 1'b0, R_LIN);
                    4'd1:    u = mk(R_T0,  R_LD1, CS_C0, 1'b0, R_LIN);
                    4'd2:    u = mk(R_LD0, R_T0,  CS_C0, 1'b1, R_LY);
                    4'd3:    u = mk(R_LD1, R_LIN, CS_C1, 1'b1, R_LY);
                    default: u = df2_op(R_RIN, R_RD0, R_RD1, R_RY, k - 4'd4);
                endcase
            end
            M_LAT:
            begin
                u = (k < 4'd5) ? lat_op(R_LIN, R_LD0, R_LD1, R_LY, k)
                               : lat_op(R_RIN, R_RD0, R_RD1, R_RY, k - 4'd5);
            end
            M_LATD:
            begin
                u = (k < 4'd5) ? lat_op(R_LIN, R_LD0, R_LD1, R_LY, k)
                               : mk(R_RY, R_LY, CS_ONE, 1'b1, R_RIN);
            end
            default: u = nop_op();
        endcase
        return u;
    endfunction

endpackage

/* src/sap_ctrl.sv */
module sap_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    output logic             out_valid,
    input  logic             out_stall,
    input  logic [1:0]       filter_order,
    input  logic [2:0]       structure_form,
    output sap_pkg::dp_cmd_t cmd
);
    import sap_pkg::*;

    state_t     state_reg, state_next;
    mode_t      mode_reg, mode_next;
    logic [3:0] step_reg, step_next;
    logic       out_valid_reg, out_valid_next;
    logic       last_step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= M_PASS;
            step_reg      <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign last_step = (step_reg == mode_len(mode_reg) - 4'd1);

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        cmd.op         = nop_op();
        in_stall       = 1'b1;
        // retire the beat on the output side
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    mode_next   = decode_mode(filter_order, structure_form);
                    step_next   = 4'd0;
                    state_next  = ST_RUN;
                end
            end
            ST_RUN:
            begin
                cmd.exec = 1'b1;
                cmd.op   = get_uop(mode_reg, step_reg);
                if (last_step)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    step_next = step_reg + 4'd1;
                end
            end
            ST_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign out_valid = out_valid_reg;

`ifndef SYNTH
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || !out_stall))
        else $error("output overwritten while pending");
    a_accept_run: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == ST_RUN && step_reg == 4'd0))
        else $error("accepted beat did not start sequence");
    a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN && last_step) |=> (state_reg == ST_DONE))
        else $error("sequence did not finish");
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (step_reg < mode_len(mode_reg)))
        else $error("step beyond program");
`endif

endmodule

/* src/sap_dp.sv */
module sap_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  sap_pkg::dp_cmd_t                    cmd,
    input  logic signed [sap_pkg::SAMPLE_W-1:0] left_in,
    input  logic signed [sap_pkg::SAMPLE_W-1:0] right_in,
    input  logic                                frame_last,
    input  logic signed [sap_pkg::COEF_W-1:0]   coef_first,
    input  logic signed [sap_pkg::COEF_W-1:0]   coef_second,
    output logic signed [sap_pkg::SAMPLE_W-1:0] left_out,
    output logic signed [sap_pkg::SAMPLE_W-1:0] right_out,
    output logic                                frame_last_out
);
    import sap_pkg::*;

    logic signed [SAMPLE_W-1:0] lin_reg, rin_reg, t0_reg, t1_reg, ly_reg, ry_reg;
    logic signed [SAMPLE_W-1:0] ld0_reg, ld1_reg, lo0_reg, lo1_reg, rd0_reg, rd1_reg;
    logic signed [SAMPLE_W-1:0] lout_reg, rout_reg;
    logic                       last_reg, last_out_reg;

    logic signed [SAMPLE_W-1:0] opa, opx, res;
    logic signed [COEF_W-1:0]   opc;
    logic signed [PROD_W-1:0]   prod, prod_rnd;
    logic signed [RPROD_W-1:0]  prod_q;
    logic signed [SUM_W-1:0]    sum;

    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((1 << (SAMPLE_W - 1)) - 1);
    localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

    function automatic logic signed [SAMPLE_W-1:0] rd(reg_sel_t s,
        logic signed [SAMPLE_W-1:0] lin, logic signed [SAMPLE_W-1:0] rin,
        logic signed [SAMPLE_W-1:0] t0,  logic signed [SAMPLE_W-1:0] t1,
        logic signed [SAMPLE_W-1:0] ly,  logic signed [SAMPLE_W-1:0] ry,
        logic signed [SAMPLE_W-1:0] ld0, logic signed [SAMPLE_W-1:0] ld1,
        logic signed [SAMPLE_W-1:0] lo0, logic signed [SAMPLE_W-1:0] lo1,
        logic signed [SAMPLE_W-1:0] rd0, logic signed [SAMPLE_W-1:0] rd1);
        logic signed [SAMPLE_W-1:0] v;
        unique case (s)
            R_LIN:   v = lin;
            R_RIN:   v = rin;
            R_T0:    v = t0;
            R_T1:    v = t1;
            R_LY:    v = ly;
            R_RY:    v = ry;
            R_LD0:   v = ld0;
            R_LD1:   v = ld1;
            R_LO0:   v = lo0;
            R_LO1:   v = lo1;
            R_RD0:   v = rd0;
            R_RD1:   v = rd1;
            default: v = '0;
        endcase
        return v;
    endfunction

    always_comb
    begin
        opa = rd(cmd.op.a, lin_reg, rin_reg, t0_reg, t1_reg, ly_reg, ry_reg,
                 ld0_reg, ld1_reg, lo0_reg, lo1_reg, rd0_reg, rd1_reg);
        opx = rd(cmd.op.x, lin_reg, rin_reg, t0_reg, t1_reg, ly_reg, ry_reg,
                 ld0_reg, ld1_reg, lo0_reg, lo1_reg, rd0_reg, rd1_reg);
        unique case (cmd.op.coef)
            CS_C0:   opc = coef_first;
            CS_C1:   opc = coef_second;
            default: opc = COEF_ONE;
        endcase
    end

    // round half up to Q1.23, then add or subtract and saturate
    assign prod     = PROD_W'(opc) * PROD_W'(opx);
    assign prod_rnd = prod + (PROD_W'(1) <<< (SHIFT - 1));
    assign prod_q   = prod_rnd[PROD_W-1:SHIFT];
    assign sum      = cmd.op.sub ? (SUM_W'(opa) - SUM_W'(prod_q))
                                 : (SUM_W'(opa) + SUM_W'(prod_q));

    always_comb
    begin
        priority if (sum > SAT_HI)
            res = SAT_HI[SAMPLE_W-1:0];
        else if (sum < SAT_LO)
            res = SAT_LO[SAMPLE_W-1:0];
        else
            res = sum[SAMPLE_W-1:0];
    end

    // filter state, cleared by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ld0_reg <= '0;
            ld1_reg <= '0;
            lo0_reg <= '0;
            lo1_reg <= '0;
            rd0_reg <= '0;
            rd1_reg <= '0;
        end
        else if (cmd.exec)
        begin
            if (cmd.op.dst == R_LD0) ld0_reg <= res;
            if (cmd.op.dst == R_LD1) ld1_reg <= res;
            if (cmd.op.dst == R_LO0) lo0_reg <= res;
            if (cmd.op.dst == R_LO1) lo1_reg <= res;
            if (cmd.op.dst == R_RD0) rd0_reg <= res;
            if (cmd.op.dst == R_RD1) rd1_reg <= res;
        end
    end

    // working and payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            lin_reg  <= left_in;
            rin_reg  <= right_in;
            last_reg <= frame_last;
        end
        if (cmd.exec)
        begin
            if (cmd.op.dst == R_T0) t0_reg <= res;
            if (cmd.op.dst == R_T1) t1_reg <= res;
            if (cmd.op.dst == R_LY) ly_reg <= res;
            if (cmd.op.dst == R_RY) ry_reg <= res;
        end
        if (cmd.load_out)
        begin
            lout_reg     <= ly_reg;
            rout_reg     <= ry_reg;
            last_out_reg <= last_reg;
        end
    end

    assign left_out       = lout_reg;
    assign right_out      = rout_reg;
    assign frame_last_out = last_out_reg;

endmodule

/* src/stereo_allpass_filter.sv */
// An accepted input beat runs the operations of the selected structure in order, one
// multiply-accumulate per cycle; pass-through has the fewest and direct form 1 the most.
// The result then moves to the output register once it is free, and only then is the
// next stereo pair accepted. All products share a single 24x24 multiplier.
// Reset clears all delay lines, sets order and form to 1 and coefficients to 0.
module stereo_allpass_filter (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [sap_pkg::SAMPLE_W-1:0] left_in,
    input  logic signed [sap_pkg::SAMPLE_W-1:0] right_in,
    input  logic                                frame_last,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [sap_pkg::SAMPLE_W-1:0] left_out,
    output logic signed [sap_pkg::SAMPLE_W-1:0] right_out,
    output logic                                frame_last_out,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [1:0]                          cfg_index,
    input  logic [sap_pkg::COEF_W-1:0]          cfg_data
);
    import sap_pkg::*;

    logic [1:0]               order_reg;
    logic [2:0]               form_reg;
    logic signed [COEF_W-1:0] c0_reg, c1_reg;
    dp_cmd_t                  cmd;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg <= ORDER_FIRST;
            form_reg  <= FORM_DF1;
            c0_reg    <= '0;
            c1_reg    <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_ORDER: order_reg <= cfg_data[1:0];
                CFG_FORM:  form_reg  <= cfg_data[2:0];
                CFG_COEF0: c0_reg    <= cfg_data;
                CFG_COEF1: c1_reg    <= cfg_data;
                default:   order_reg <= order_reg;
            endcase
        end
    end

    sap_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .filter_order   (order_reg),
        .structure_form (form_reg),
        .cmd            (cmd)
    );

    sap_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .left_in        (left_in),
        .right_in       (right_in),
        .frame_last     (frame_last),
        .coef_first     (c0_reg),
        .coef_second    (c1_reg),
        .left_out       (left_out),
        .right_out      (right_out),
        .frame_last_out (frame_last_out)
    );

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
    import sap_pkg::*;

    localparam int  HOLD_CYCLES = 300;
    localparam int  DRAIN_WAIT  = 40;
    localparam int  LIMIT       = 400000;
    localparam int  RAND_PHASES = 10;
    localparam int  PHASE_ITEMS = 70;
    localparam longint SMAX     = 64'sd8388607;
    localparam longint SMIN     = -64'sd8388608;

    typedef enum logic {ROW_CFG, ROW_SMP} row_kind_t;

    typedef struct packed {
        row_kind_t           kind;
        logic [1:0]          idx;
        logic [SAMPLE_W-1:0] l;
        logic [SAMPLE_W-1:0] r;
        logic                last;
        logic                typed;
        logic [SAMPLE_W-1:0] el;
        logic [SAMPLE_W-1:0] er;
    } stim_row_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] l;
        logic [SAMPLE_W-1:0] r;
        logic                last;
    } pair_t;

    localparam int NROWS = 24;
    // For config rows the l field carries the register value.
    localparam stim_row_t DIR_TAB [0:NROWS-1] = '{
        '{ROW_SMP, 2'd0,      24'h7FFFFF, 24'h800000, 1'b1, 1'b1, 24'h000000, 24'h800000},
        '{ROW_SMP, 2'd0,      24'h800000, 24'h7FFFFF, 1'b0, 1'b1, 24'h7FFFFF, 24'h7FFFFF},
        '{ROW_CFG, CFG_ORDER, 24'h000000, 24'h0, 1'b0, 1'b0, 24'h0, 24'h0},
        '{ROW_SMP, 2'd0,      24'h800000, 24'h7FFFFF, 1'b1, 1'b1, 24'h800000, 24'h7FFFFF},
        '{ROW_SMP, 2'd0,      24'h000001, 24'hFFFFFF, 1'b0, 1'b1, 24'h000001, 24'hFFFFFF},
        '{ROW_CFG, CFG_ORDER, 24'h000002, 24'h0, 1'b0, 1'b0, 24'h0, 24'h0},
        '{ROW_CFG, CFG_FORM,  24'h000007, 24'h0, 1'b0, 1'b0, 24'h0, 24'h0},
        '{ROW_SMP, 2'd0,      24'h123456, 24'hABCDEF, 1'b1, 1'b1, 24'h123456, 24'hABCDEF},
        '{ROW_CFG, CFG_COEF0, 24'h7FFFFF, 24'h0, 1'b0, 1'b0, 24'h0, 24'h0},
        '{ROW_CFG, CFG_COEF1, 24'h800000, 24'h0, 1'b0, 1'b0, 24'h0, 24'h0},
        '{ROW_CFG, CFG_FORM,  24'h000001, 24'h0, 1'b0, 1'b0, 24'h0, 24'h0},
        '{ROW_SMP, 2'd0,      24'h7FFFFF, 24'h800000, 1'b0, 1'b0, 24'h0, 24'h0},
        '{ROW_SMP, 2'd0,      24'h800000, 24'h7FFFFF, 1'b1, 1'b0, 24'h0, 24'h0},
        '{ROW_CFG, CFG_FORM,  24'h000002, 24'h0, 1'b0, 1'b0, 24'h0, 24'h0},
        '{ROW_SMP, 2'd0,      24'h7FFFFF, 24'h7FFFFF, 1'b0, 1'b0, 24'h0, 24'h0},
        '{ROW_CFG, CFG_FORM,  24'h000003, 24'h0, 1'b0, 1'b0, 24'h0, 24'h0},
        '{ROW_SMP, 2'd0,      24'h800000, 24'h000000, 1'b1, 1'b0, 24'h0, 24'h0},
        '{ROW_CFG, CFG_FORM,  24'h000004, 24'h0, 1'b0, 1'b0, 24'h0, 24'h0},
        '{ROW_SMP, 2'd0,      24'h400000, 24'hC00000, 1'b0, 1'b0, 24'h0, 24'h0},
        '{ROW_CFG, CFG_FORM,  24'h000005, 24'h0, 1'b0, 1'b0, 24'h0, 24'h0},
        '{ROW_SMP, 2'd0,      24'h7FFFFF, 24'h800000, 1'b1, 1'b0, 24'h0, 24'h0},
        '{ROW_CFG, CFG_FORM,  24'h000006, 24'h0, 1'b0, 1'b0, 24'h0, 24'h0},
        '{ROW_SMP, 2'd0,      24'h000000, 24'h800000, 1'b0, 1'b0, 24'h0, 24'h0},
        '{ROW_SMP, 2'd0,      24'h800000, 24'h7FFFFF, 1'b1, 1'b0, 24'h0, 24'h0}
    };

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic signed [SAMPLE_W-1:0] left_in = '0;
    logic signed [SAMPLE_W-1:0] right_in = '0;
    logic                       frame_last = 1'b0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic signed [SAMPLE_W-1:0] left_out;
    logic signed [SAMPLE_W-1:0] right_out;
    logic                       frame_last_out;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [1:0]                 cfg_index = '0;
    logic [COEF_W-1:0]          cfg_data = '0;

    // predictor copy of the block's registers and delay lines
    logic [1:0] cur_order;
    logic [2:0] cur_form;
    longint     k0, k1;
    longint     ld0, ld1, lo0, lo1, rd0, rd1;

    pair_t  pending_q[$];
    int     n_errors = 0;
    int     cycle_cnt = 0;
    int     hold_cnt = 0;
    bit     quiet = 1'b0;

    stereo_allpass_filter dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .left_in(left_in), .right_in(right_in), .frame_last(frame_last),
        .out_valid(out_valid), .out_stall(out_stall),
        .left_out(left_out), .right_out(right_out), .frame_last_out(frame_last_out),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic longint sat(longint v);
        if (v > SMAX)
            return SMAX;
        if (v < SMIN)
            return SMIN;
        return v;
    endfunction

    // round half up to Q1.23, arithmetic shift floors
    function automatic longint rprod(longint c, longint x);
        return (c * x + 64'sd2097152) >>> (COEF_W - 2);
    endfunction

    function automatic longint mac(longint a, longint c, longint x);
        return sat(a + rprod(c, x));
    endfunction

    function automatic longint msub(longint a, longint c, longint x);
        return sat(a - rprod(c, x));
    endfunction

    task automatic first_sec(input longint x, inout longint d0, output longint y);
        longint xh;
        xh = msub(x, k0, d0);
        y  = mac(d0, k0, xh);
        d0 = xh;
    endtask

    task automatic lattice_sec(input longint x, inout longint d0, inout longint d1,
                               output longint y);
        longint xh, t;
        xh = msub(x, k1, d1);
        y  = mac(d1, k1, xh);
        first_sec(xh, d0, t);
        d1 = t;
    endtask

    task automatic df2_sec(input longint x, inout longint d0, inout longint d1,
                           output longint y);
        longint xh;
        xh = msub(x, k0, d0);
        xh = msub(xh, k1, d1);
        y  = sat(rprod(k1, xh));
        y  = mac(y, k0, d0);
        y  = sat(y + d1);
        d1 = d0;
        d0 = xh;
    endtask

    task automatic df1_left(input longint x, output longint y);
        y   = mac(ld1, k0, ld0);
        y   = mac(y, k1, x);
        y   = msub(y, k1, lo1);
        y   = msub(y, k0, lo0);
        ld1 = ld0;
        ld0 = x;
        lo1 = lo0;
        lo0 = y;
    endtask

    task automatic df1t_left(input longint x, output longint y);
        longint xh;
        xh  = sat(x + ld0);
        ld0 = msub(ld1, k0, xh);
        ld1 = sat(-sat(rprod(k1, xh)));
        y   = mac(lo0, k1, xh);
        lo0 = mac(lo1, k0, xh);
        lo1 = xh;
    endtask

    task automatic df2t_left(input longint x, output longint y);
        y   = mac(ld0, k1, x);
        ld0 = mac(ld1, k0, x);
        ld0 = msub(ld0, k0, y);
        ld1 = msub(x, k1, y);
    endtask

    task automatic filter_pair(input pair_t p, output pair_t q);
        longint l, r, yl, yr;
        l  = longint'($signed(p.l));
        r  = longint'($signed(p.r));
        yl = l;
        yr = r;
        if (cur_order == ORDER_FIRST)
        begin
            first_sec(l, ld0, yl);
        end
        else if (cur_order == ORDER_SECOND)
        begin
            unique case (cur_form)
                FORM_DF1:  df1_left(l, yl);
                FORM_DF1T: df1t_left(l, yl);
                FORM_DF2:  df2_sec(l, ld0, ld1, yl);
                FORM_DF2T: df2t_left(l, yl);
                FORM_LAT:  lattice_sec(l, ld0, ld1, yl);
                FORM_LATD: lattice_sec(l, ld0, ld1, yl);
                default:   ;
            endcase
            unique case (cur_form)
                FORM_DF1, FORM_DF1T, FORM_DF2, FORM_DF2T: df2_sec(r, rd0, rd1, yr);
                FORM_LAT:  lattice_sec(r, rd0, rd1, yr);
                FORM_LATD: yr = sat(yl - r);
                default:   ;
            endcase
        end
        q.l    = yl[SAMPLE_W-1:0];
        q.r    = yr[SAMPLE_W-1:0];
        q.last = p.last;
    endtask

    task automatic report_mismatch(input string what, input logic [SAMPLE_W-1:0] got,
                                   input logic [SAMPLE_W-1:0] want);
        $display("MISMATCH %s: got %h expected %h at cycle %0d", what, got, want,
                 cycle_cnt);
        n_errors++;
    endtask

    // result side: check each beat, then pick the next stall
    always @(posedge clk)
    begin
        pair_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_q.size() == 0)
            begin
                report_mismatch("unexpected beat", left_out, '0);
            end
            else
            begin
                want = pending_q.pop_front();
                if (left_out !== want.l)
                    report_mismatch("left_out", left_out, want.l);
                if (right_out !== want.r)
                    report_mismatch("right_out", right_out, want.r);
                if (frame_last_out !== want.last)
                    report_mismatch("frame_last_out", frame_last_out, want.last);
            end
        end
        if (hold_cnt > 0)
        begin
            out_stall <= 1'b1;
            hold_cnt  <= hold_cnt - 1;
        end
        else
        begin
            out_stall <= !quiet && ($urandom_range(0, 99) < 34);
        end
    end

    task automatic drain;
        in_valid <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [COEF_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        unique case (idx)
            CFG_ORDER: cur_order = val[1:0];
            CFG_FORM:  cur_form  = val[2:0];
            CFG_COEF0: k0 = longint'($signed(val));
            default:   k1 = longint'($signed(val));
        endcase
    endtask

    // offer one beat and hold it until accepted; returns the predicted result
    task automatic send_pair(input pair_t p, output pair_t q);
        int gap;
        gap = (!quiet && $urandom_range(0, 99) < 34) ? $urandom_range(1, 4) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        left_in    <= p.l;
        right_in   <= p.r;
        frame_last <= p.last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        filter_pair(p, q);
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        unique case ($urandom_range(0, 9))
            0:       return 24'h7FFFFF;
            1:       return 24'h800000;
            2:       return 24'h000000;
            3:       return 24'(int'($urandom_range(0, 511)) - 256);
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic logic [COEF_W-1:0] pick_coef();
        unique case ($urandom_range(0, 7))
            0:       return 24'h7FFFFF;
            1:       return 24'h800000;
            2:       return 24'h000000;
            3:       return 24'h400000;
            default: return 24'($urandom);
        endcase
    endfunction

    initial
    begin
        pair_t p, q;
        int    n;
        cur_order = ORDER_FIRST;
        cur_form  = FORM_DF1;
        k0 = 0;
        k1 = 0;
        ld0 = 0; ld1 = 0; lo0 = 0; lo1 = 0; rd0 = 0; rd1 = 0;
        n = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NROWS; i++)
        begin
            if (DIR_TAB[i].kind == ROW_CFG)
            begin
                drain();
                write_reg(DIR_TAB[i].idx, DIR_TAB[i].l);
            end
            else
            begin
                p = '{l: DIR_TAB[i].l, r: DIR_TAB[i].r, last: DIR_TAB[i].last};
                send_pair(p, q);
                if (DIR_TAB[i].typed)
                    q = '{l: DIR_TAB[i].el, r: DIR_TAB[i].er, last: DIR_TAB[i].last};
                pending_q.push_back(q);
            end
        end

        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            drain();
            // favor second order; first phase and last phase hit coefficient extremes
            write_reg(CFG_ORDER, ($urandom_range(0, 9) < 6) ? 24'(ORDER_SECOND)
                                                             : 24'($urandom_range(0, 3)));
            write_reg(CFG_FORM, 24'($urandom_range(0, 7)));
            write_reg(CFG_COEF0, (ph == 0) ? 24'h800000 : (ph == RAND_PHASES - 1)
                                           ? 24'h7FFFFF : pick_coef());
            write_reg(CFG_COEF1, (ph == 0) ? 24'h7FFFFF : (ph == RAND_PHASES - 1)
                                           ? 24'h800000 : pick_coef());
            for (int j = 0; j < PHASE_ITEMS; j++)
            begin
                quiet = (n >= 100 && n < 220);
                if (n == 350)
                    hold_cnt = HOLD_CYCLES;
                if (n == 500)
                begin
                    in_valid <= 1'b0;
                    while (pending_q.size() != 0)
                        @(posedge clk);
                end
                p = '{l: pick_sample(), r: pick_sample(), last: 1'($urandom_range(0, 1))};
                send_pair(p, q);
                pending_q.push_back(q);
                n++;
            end
        end
        quiet = 1'b0;

        in_valid <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (n_errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
